// ===== src/assert_macros.svh =====
// Assertion macros used by the top level to check block behavior.
// No dependencies; taken in by `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clk edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== src/bsha_pkg.sv =====
// Shared types and constants for the broken SHA-1 hash block.
// No dependencies.
package bsha_pkg;

    localparam int NUM_CHAIN   = 5;
    localparam int BLOCK_WORDS = 16;
    localparam int ROUNDS      = 80;

    typedef logic [31:0] word_t;

    localparam word_t INIT_CHAIN [NUM_CHAIN] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam word_t K_CH   = 32'h5A827999;
    localparam word_t K_PAR  = 32'h6ED9EBA1;
    localparam word_t K_MAJ  = 32'h8F1BBCDC;  // two's complement of 0x70E44324
    localparam word_t K_PAR2 = 32'hCA62C1D6;  // two's complement of 0x359D3E2A

    localparam int ROT_A = 5;
    localparam int ROT_B = 30;

    typedef enum logic [1:0] {
        PH_CH,
        PH_PAR,
        PH_MAJ,
        PH_PAR2
    } phase_t;

    typedef struct packed {
        logic   accept;   // input request taken this cycle
        logic   load;     // block and chain into working registers
        logic   round;    // one compression round
        logic   fold;     // add working registers into chain
        logic   emit;     // digest into output buffer, chain back to init
        phase_t phase;
    } bsha_cmd_t;

    typedef struct packed {
        logic need_comp;  // current input request fills the block, or is final with bytes held
        logic obuf_busy;  // digest buffer still draining
    } bsha_status_t;

endpackage

// ===== src/bsha_if.sv =====
// Valid/ready channel interfaces for message bytes in and digest words out.
// No dependencies.
interface bsha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       final_item;

    modport source (output valid, output data_byte, output byte_present,
                    output final_item, input ready);
    modport sink   (input valid, input data_byte, input byte_present,
                    input final_item, output ready);
endinterface

interface bsha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic        digest_last;

    modport source (output valid, output digest_word, output digest_last, input ready);
    modport sink   (input valid, input digest_word, input digest_last, output ready);
endinterface

// ===== src/bsha_ctrl.sv =====
// Sequencer for the broken SHA-1 block: request acceptance, round count, fold.
// Depends on bsha_pkg.
module bsha_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_final,
    output logic                  in_ready,
    input  bsha_pkg::bsha_status_t status,
    output bsha_pkg::bsha_cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_LOAD  = 4'b0010,
        S_ROUND = 4'b0100,
        S_FOLD  = 4'b1000
    } state_t;

    localparam int RND_W = $clog2(bsha_pkg::ROUNDS);

    state_t           state_reg, state_next;
    logic [RND_W-1:0] rnd_reg, rnd_next;
    logic             fin_reg, fin_next;
    logic             accept;

    assign in_ready = (state_reg == S_IDLE) && !(in_final && status.obuf_busy);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        fin_next   = fin_reg;
        cmd        = '0;
        cmd.phase  = bsha_pkg::PH_CH;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accept = accept;
                if (accept)
                begin
                    if (status.need_comp)
                    begin
                        fin_next   = in_final;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        cmd.emit = in_final;
                    end
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                rnd_next   = '0;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round = 1'b1;
                priority if (rnd_reg < RND_W'(20))
                    cmd.phase = bsha_pkg::PH_CH;
                else if (rnd_reg < RND_W'(40))
                    cmd.phase = bsha_pkg::PH_PAR;
                else if (rnd_reg < RND_W'(60))
                    cmd.phase = bsha_pkg::PH_MAJ;
                else
                    cmd.phase = bsha_pkg::PH_PAR2;
                rnd_next = rnd_reg + RND_W'(1);
                if (rnd_reg == RND_W'(bsha_pkg::ROUNDS - 1))
                    state_next = S_FOLD;
            end
            S_FOLD:
            begin
                cmd.fold   = 1'b1;
                cmd.emit   = fin_reg;
                fin_next   = 1'b0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rnd_reg   <= '0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            fin_reg   <= fin_next;
        end
    end

endmodule

// ===== src/bsha_datapath.sv =====
// Datapath: byte packing, schedule window, round unit, chain and digest buffer.
// Depends on bsha_pkg.
module bsha_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  bsha_pkg::bsha_cmd_t    cmd,
    input  logic [7:0]             data_byte,
    input  logic                   byte_present,
    input  logic                   final_item,
    output bsha_pkg::bsha_status_t status,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [31:0]            digest_word,
    output logic                   digest_last
);

    localparam int OIDX_W = $clog2(bsha_pkg::NUM_CHAIN);

    bsha_pkg::word_t block_reg [bsha_pkg::BLOCK_WORDS];
    bsha_pkg::word_t block_next [bsha_pkg::BLOCK_WORDS];
    bsha_pkg::word_t win_reg [bsha_pkg::BLOCK_WORDS];
    bsha_pkg::word_t chain_reg [bsha_pkg::NUM_CHAIN];
    bsha_pkg::word_t chain_next [bsha_pkg::NUM_CHAIN];
    bsha_pkg::word_t obuf_reg [bsha_pkg::NUM_CHAIN];
    bsha_pkg::word_t sum [bsha_pkg::NUM_CHAIN];
    bsha_pkg::word_t a_reg, b_reg, c_reg, d_reg, e_reg;
    bsha_pkg::word_t f_val, k_val, t_val, sched_x;

    logic [5:0]        fill_reg, fill_next;
    logic              obuf_valid_reg, obuf_valid_next;
    logic [OIDX_W-1:0] out_idx_reg, out_idx_next;
    logic              out_take;

    assign status.need_comp = byte_present ? ((fill_reg == 6'd63) || final_item)
                                           : (final_item && (fill_reg != 6'd0));
    assign status.obuf_busy = obuf_valid_reg;

    // block buffer and fill count
    always_comb
    begin
        block_next = block_reg;
        fill_next  = fill_reg;
        if (cmd.load)
        begin
            for (int i = 0; i < bsha_pkg::BLOCK_WORDS; i++)
                block_next[i] = '0;
        end
        else if (cmd.accept)
        begin
            if (byte_present)
                block_next[fill_reg[5:2]][{fill_reg[1:0], 3'b000} +: 8] = data_byte;
            fill_next = status.need_comp ? 6'd0 : fill_reg + {5'd0, byte_present};
        end
    end

    // round function
    always_comb
    begin
        unique case (cmd.phase)
            bsha_pkg::PH_CH:
            begin
                f_val = (b_reg & c_reg) | (~b_reg & d_reg);
                k_val = bsha_pkg::K_CH;
            end
            bsha_pkg::PH_PAR:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = bsha_pkg::K_PAR;
            end
            bsha_pkg::PH_MAJ:
            begin
                f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
                k_val = bsha_pkg::K_MAJ;
            end
            bsha_pkg::PH_PAR2:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = bsha_pkg::K_PAR2;
            end
            default:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = bsha_pkg::K_PAR2;
            end
        endcase
        t_val = {a_reg[31-bsha_pkg::ROT_A:0], a_reg[31:32-bsha_pkg::ROT_A]}
              + f_val + e_reg + win_reg[0] + k_val;
        sched_x = win_reg[0] ^ win_reg[2] ^ win_reg[8] ^ win_reg[13];
    end

    // chain update and digest capture
    always_comb
    begin
        sum[0] = chain_reg[0] + a_reg;
        sum[1] = chain_reg[1] + b_reg;
        sum[2] = chain_reg[2] + c_reg;
        sum[3] = chain_reg[3] + d_reg;
        sum[4] = chain_reg[4] + e_reg;
        chain_next = chain_reg;
        if (cmd.emit)
            chain_next = bsha_pkg::INIT_CHAIN;
        else if (cmd.fold)
            chain_next = sum;
    end

    assign out_take = obuf_valid_reg && out_ready;

    always_comb
    begin
        obuf_valid_next = obuf_valid_reg;
        out_idx_next    = out_idx_reg;
        if (cmd.emit)
        begin
            obuf_valid_next = 1'b1;
            out_idx_next    = '0;
        end
        else if (out_take)
        begin
            if (out_idx_reg == OIDX_W'(bsha_pkg::NUM_CHAIN - 1))
            begin
                obuf_valid_next = 1'b0;
                out_idx_next    = '0;
            end
            else
            begin
                out_idx_next = out_idx_reg + OIDX_W'(1);
            end
        end
    end

    assign out_valid   = obuf_valid_reg;
    assign digest_word = obuf_reg[out_idx_reg];
    assign digest_last = (out_idx_reg == OIDX_W'(bsha_pkg::NUM_CHAIN - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bsha_pkg::BLOCK_WORDS; i++)
                block_reg[i] <= '0;
            chain_reg      <= bsha_pkg::INIT_CHAIN;
            fill_reg       <= '0;
            obuf_valid_reg <= 1'b0;
            out_idx_reg    <= '0;
        end
        else
        begin
            block_reg      <= block_next;
            chain_reg      <= chain_next;
            fill_reg       <= fill_next;
            obuf_valid_reg <= obuf_valid_next;
            out_idx_reg    <= out_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            win_reg <= block_reg;
            a_reg   <= chain_reg[0];
            b_reg   <= chain_reg[1];
            c_reg   <= chain_reg[2];
            d_reg   <= chain_reg[3];
            e_reg   <= chain_reg[4];
        end
        else if (cmd.round)
        begin
            for (int i = 0; i < bsha_pkg::BLOCK_WORDS - 1; i++)
                win_reg[i] <= win_reg[i+1];
            win_reg[bsha_pkg::BLOCK_WORDS-1] <= 32'd1 << sched_x[4:0];
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[31-bsha_pkg::ROT_B:0], b_reg[31:32-bsha_pkg::ROT_B]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
        if (cmd.emit)
        begin
            if (cmd.fold)
                obuf_reg <= sum;
            else
                obuf_reg <= chain_reg;
        end
    end

endmodule

// ===== src/broken_sha1_hash.sv =====
// Top level of the broken SHA-1 (XSHA-1) hash block.
// Depends on bsha_pkg, bsha_if, bsha_ctrl, bsha_datapath and assert_macros.svh.
//
// Message bytes come in one request at a time and are packed little-endian
// into a 64-byte block. A request that completes no block leaves the
// sequencer idle. A request that fills the block, or a final request with
// bytes still held, holds off the input while the block is loaded, run through
// 80 rounds in the single round unit and folded into the chain. On a final
// request the five digest words go out from a buffer one per cycle while
// out_ready is high, word 0 first, digest_last on the fifth; the next message
// may start while they drain, but its final request waits until the buffer
// is empty. An empty message yields the initial values.
module broken_sha1_hash (
    input logic          clk,
    input logic          rst_n,
    bsha_in_if.sink      in_ch,
    bsha_out_if.source   out_ch
);

    `include "assert_macros.svh"

    bsha_pkg::bsha_cmd_t    cmd;
    bsha_pkg::bsha_status_t status;

    bsha_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_final (in_ch.final_item),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    bsha_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .data_byte    (in_ch.data_byte),
        .byte_present (in_ch.byte_present),
        .final_item   (in_ch.final_item),
        .status       (status),
        .out_valid    (out_ch.valid),
        .out_ready    (out_ch.ready),
        .digest_word  (out_ch.digest_word),
        .digest_last  (out_ch.digest_last)
    );

    `ASSERT_PROP(a_final_needs_empty_buf, (in_ch.valid && in_ch.ready && in_ch.final_item) |-> !out_ch.valid, "final request taken while digest buffer busy")
    `ASSERT_PROP(a_emit_into_empty_buf, cmd.emit |-> !out_ch.valid, "digest overwrote undelivered words")
    `ASSERT_PROP(a_load_after_accept, cmd.load |-> $past(cmd.accept), "block load without a completing request")
    `ASSERT_NEVER(a_no_accept_in_round, (in_ch.ready && (cmd.round || cmd.load || cmd.fold)), "input ready during compression")

endmodule

// ===== bench/tb_broken_sha1_hash.sv =====
// Self-checking testbench for broken_sha1_hash: feeds message bytes and compares every digest
// word against an in-bench model of the broken SHA-1 hash.
// Depends on bsha_if (bsha_in_if, bsha_out_if) and the broken_sha1_hash RTL.
`timescale 1ns / 100ps

module tb_broken_sha1_hash;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;
    localparam logic [31:0] RK0 = 32'h5A827999;
    localparam logic [31:0] RK1 = 32'h6ED9EBA1;
    localparam logic [31:0] RK2 = 32'h8F1BBCDC;
    localparam logic [31:0] RK3 = 32'hCA62C1D6;
    localparam int NUM_REQS    = 110;
    localparam int MAX_REPORTS = 10;

    typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_mode_t;

    typedef struct {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       final_item;
    } byte_req_t;

    typedef struct {
        logic [31:0] word;
        logic        last;
    } digest_word_t;

    logic clk;
    logic rst_n;

    bsha_in_if  in_ch ();
    bsha_out_if out_ch ();

    broken_sha1_hash dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    byte_req_t    req_q[$];
    digest_word_t digest_q[$];

    logic [31:0] chain_st[5];
    logic [31:0] block_st[16];
    int unsigned fill_st;

    int  mismatches;
    int  msg_reqs;
    bit  in_fire;
    bit  out_fire;
    bit  in_busy;
    int  in_gap;
    int  in_quiet;
    int  out_hold;
    int  out_quiet;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] rotl(logic [31:0] x, int s);
        s = s % 32;
        if (s == 0)
            return x;
        return (x << s) | (x >> (32 - s));
    endfunction

    function automatic int pick_gap(inout int quiet);
        int r;
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
        begin
            quiet = $urandom_range(20, 60);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic reset_hash_state();
        chain_st = '{IV0, IV1, IV2, IV3, IV4};
        foreach (block_st[i])
            block_st[i] = '0;
        fill_st = 0;
    endtask

    task automatic compress_block();
        logic [31:0] w[80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
            w[i] = block_st[i];
        for (int i = 16; i < 80; i++)
        begin
            t = w[i-16] ^ w[i-14] ^ w[i-8] ^ w[i-3];
            w[i] = 32'd1 << t[4:0];
        end
        a = chain_st[0];
        b = chain_st[1];
        c = chain_st[2];
        d = chain_st[3];
        e = chain_st[4];
        for (int i = 0; i < 80; i++)
        begin
            if (i < 20)
            begin
                f = (b & c) | (~b & d);
                k = RK0;
            end
            else if (i < 40)
            begin
                f = b ^ c ^ d;
                k = RK1;
            end
            else if (i < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = RK2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = RK3;
            end
            t = rotl(a, 5) + f + e + w[i] + k;
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        chain_st[0] += a;
        chain_st[1] += b;
        chain_st[2] += c;
        chain_st[3] += d;
        chain_st[4] += e;
        foreach (block_st[i])
            block_st[i] = '0;
        fill_st = 0;
    endtask

    task automatic hash_request(byte_req_t r);
        digest_word_t dw;
        if (r.byte_present)
        begin
            block_st[fill_st / 4] |= {24'd0, r.data_byte} << (8 * (fill_st % 4));
            fill_st++;
            if (fill_st == 64)
                compress_block();
        end
        if (r.final_item)
        begin
            if (fill_st != 0)
                compress_block();
            for (int i = 0; i < 5; i++)
            begin
                dw.word = chain_st[i];
                dw.last = (i == 4);
                digest_q = {digest_q, dw};
            end
            reset_hash_state();
        end
    endtask

    task automatic push_req(logic [7:0] data, logic present, logic fin);
        byte_req_t r;
        r.data_byte = data;
        r.byte_present = present;
        r.final_item = fin;
        req_q = {req_q, r};
        msg_reqs++;
    endtask

    // noise requests carry neither a byte nor the end mark
    task automatic add_message(int len, bit last_carries_final, fill_mode_t mode, int noise_pct);
        logic [7:0] data;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                push_req(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            case (mode)
                FILL_ONES:  data = 8'hFF;
                FILL_ZEROS: data = 8'h00;
                default:    data = 8'($urandom_range(0, 255));
            endcase
            push_req(data, 1'b1, last_carries_final && (i == len - 1));
        end
        if (len == 0 || !last_carries_final)
            push_req(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    always @(posedge clk)
    begin
        byte_req_t    r;
        digest_word_t want;
        in_fire  = rst_n && in_ch.valid && in_ch.ready;
        out_fire = rst_n && out_ch.valid && out_ch.ready;
        if (in_fire)
        begin
            r.data_byte    = in_ch.data_byte;
            r.byte_present = in_ch.byte_present;
            r.final_item   = in_ch.final_item;
            hash_request(r);
        end
        if (out_fire)
        begin
            if (digest_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected digest word %h last %b", $time,
                             out_ch.digest_word, out_ch.digest_last);
            end
            else
            begin
                want = digest_q.pop_front();
                if (out_ch.digest_word !== want.word || out_ch.digest_last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: digest mismatch: expected %h last %b, got %h last %b",
                                 $time, want.word, want.last,
                                 out_ch.digest_word, out_ch.digest_last);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        byte_req_t r;
        if (rst_n)
        begin
            if (in_fire)
                in_busy = 1'b0;
            if (!in_busy)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_ch.valid <= 1'b0;
                end
                else if (req_q.size() != 0)
                begin
                    r = req_q.pop_front();
                    in_ch.data_byte    <= r.data_byte;
                    in_ch.byte_present <= r.byte_present;
                    in_ch.final_item   <= r.final_item;
                    in_ch.valid        <= 1'b1;
                    in_busy = 1'b1;
                    in_gap  = pick_gap(in_quiet);
                end
                else
                    in_ch.valid <= 1'b0;
            end

            if (out_hold > 0)
            begin
                out_hold--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    out_hold = pick_gap(out_quiet);
            end
        end
    end

    initial
    begin
        int len;
        in_ch.valid        = 1'b0;
        in_ch.data_byte    = 8'h00;
        in_ch.byte_present = 1'b0;
        in_ch.final_item   = 1'b0;
        out_ch.ready       = 1'b0;
        rst_n      = 1'b0;
        mismatches = 0;
        msg_reqs   = 0;
        in_busy    = 1'b0;
        in_gap     = 0;
        in_quiet   = 0;
        out_hold   = 0;
        out_quiet  = 0;
        in_fire    = 1'b0;
        out_fire   = 1'b0;
        reset_hash_state();

        // directed: empty messages back to back, extremes of the byte,
        // end mark with and without a byte, ignored requests, exact block
        add_message(0, 1'b0, FILL_RANDOM, 0);
        add_message(0, 1'b0, FILL_RANDOM, 0);
        add_message(1, 1'b1, FILL_ONES, 0);
        push_req(8'hFF, 1'b0, 1'b0);
        push_req(8'h00, 1'b0, 1'b0);
        add_message(4, 1'b1, FILL_ZEROS, 0);
        add_message(3, 1'b0, FILL_RANDOM, 0);
        add_message(64, 1'b0, FILL_RANDOM, 0);

        while (msg_reqs < NUM_REQS)
        begin
            case ($urandom_range(0, 11))
                0:       len = $urandom_range(13, 24);
                1:       len = 0;
                default: len = $urandom_range(1, 12);
            endcase
            add_message(len, 1'($urandom_range(0, 1)), FILL_RANDOM, 10);
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (req_q.size() != 0 || in_busy || digest_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (mismatches == 0 && digest_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== broken_sha1_hash.f =====
+incdir+src
src/bsha_pkg.sv
src/bsha_if.sv
src/bsha_ctrl.sv
src/bsha_datapath.sv
src/broken_sha1_hash.sv
bench/tb_broken_sha1_hash.sv
